>>> rtl/nfd_pkg.sv
// ----------------------------------------------------------------------------
// nfd_pkg
// Shared types and constants for the NV12 frame decimator.
// ----------------------------------------------------------------------------
package nfd_pkg;

    localparam int unsigned FACTOR_W  = 8;
    localparam int unsigned DIM_W     = 14;
    localparam int unsigned STRIDE_W  = 15;
    localparam int unsigned CFG_W     = 15;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned HDR_LEN   = 16;
    localparam int unsigned HDR_IDX_W = 4;
    localparam int unsigned DIV_STEPS = DIM_W;
    localparam int unsigned DIV_CNT_W = 4;

    localparam logic [LEN_W-1:0] HDR_MAGIC = 32'h3146_474D;  // "MGF1", M in low byte

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_STR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_STR = 3'd4;

    localparam logic [FACTOR_W-1:0] RST_FACTOR     = 8'd1;
    localparam logic [DIM_W-1:0]    RST_SRC_WIDTH  = 14'd640;
    localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT = 14'd480;
    localparam logic [STRIDE_W-1:0] RST_STRIDE     = 15'd640;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_W,
        ST_DIV_H,
        ST_MUL,
        ST_HDR,
        ST_PIX
    } state_t;

    typedef struct packed {
        logic step;
        logic clear;
        logic chroma;
    } pix_ctrl_t;

    typedef struct packed {
        logic kept;
        logic done;
    } pix_stat_t;

endpackage

>>> rtl/nfd_div.sv
// ----------------------------------------------------------------------------
// nfd_div
// Restoring divider, one quotient bit per cycle, shared for width and height.
// ----------------------------------------------------------------------------
module nfd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nfd_pkg::DIM_W-1:0]     dividend,
    input  logic [nfd_pkg::FACTOR_W-1:0]  divisor,
    output logic                          done,
    output logic [nfd_pkg::DIM_W-1:0]     quotient
);

    logic [nfd_pkg::FACTOR_W-1:0]  rem_reg, rem_next;
    logic [nfd_pkg::FACTOR_W-1:0]  dvs_reg, dvs_next;
    logic [nfd_pkg::DIM_W-1:0]     quo_reg, quo_next;
    logic [nfd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [nfd_pkg::FACTOR_W:0]    trial;
    logic                          qbit;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[nfd_pkg::DIM_W-1]};
        qbit      = (trial >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (qbit)
                rem_next = nfd_pkg::FACTOR_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[nfd_pkg::FACTOR_W-1:0];
            quo_next = {quo_reg[nfd_pkg::DIM_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == nfd_pkg::DIV_CNT_W'(nfd_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/nfd_pix.sv
// ----------------------------------------------------------------------------
// nfd_pix
// Row and column counters of the current plane and the keep decision.
// ----------------------------------------------------------------------------
module nfd_pix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nfd_pkg::pix_ctrl_t            ctrl,
    input  logic [nfd_pkg::FACTOR_W-1:0]  factor,
    input  logic [nfd_pkg::STRIDE_W-1:0]  luma_stride,
    input  logic [nfd_pkg::STRIDE_W-1:0]  chroma_stride,
    input  logic [nfd_pkg::DIM_W-1:0]     out_width,
    input  logic [nfd_pkg::DIM_W-1:0]     out_height,
    output nfd_pkg::pix_stat_t            stat
);

    logic [nfd_pkg::STRIDE_W-1:0] bir_reg, bir_next, bir_eff;
    logic [nfd_pkg::FACTOR_W-1:0] rp_reg, rp_next, rp_eff;
    logic [nfd_pkg::FACTOR_W-1:0] cp_reg, cp_next, cp_eff;
    logic [nfd_pkg::DIM_W-1:0]    kr_reg, kr_next, kr_eff;
    logic [nfd_pkg::DIM_W-1:0]    kc_reg, kc_next, kc_eff;
    logic [nfd_pkg::STRIDE_W-1:0] stride;
    logic [nfd_pkg::DIM_W-1:0]    row_limit;
    logic [nfd_pkg::DIM_W-1:0]    kc_inc;
    logic [nfd_pkg::FACTOR_W:0]   cp_inc, rp_inc;
    logic [nfd_pkg::STRIDE_W:0]   bir_inc;
    logic                         row_kept, col_ok, row_end;

    always_comb
    begin
        bir_eff = ctrl.clear ? '0 : bir_reg;
        rp_eff  = ctrl.clear ? '0 : rp_reg;
        cp_eff  = ctrl.clear ? '0 : cp_reg;
        kr_eff  = ctrl.clear ? '0 : kr_reg;
        kc_eff  = ctrl.clear ? '0 : kc_reg;

        stride = ctrl.chroma ? chroma_stride : luma_stride;
        if (stride == '0)
            stride = nfd_pkg::STRIDE_W'(1);
        row_limit = ctrl.chroma ? (out_height >> 1) : out_height;

        row_kept = (rp_eff == '0) && (kr_eff < row_limit);
        col_ok   = (cp_eff == '0) && (kc_eff < out_width);
        kc_inc   = kc_eff + 1'b1;

        stat.kept = row_kept && col_ok;
        stat.done = ctrl.chroma && (row_limit != '0) && (kr_eff == row_limit - 1'b1)
                    && (kc_inc == out_width);

        cp_inc = {1'b0, cp_eff} + 1'b1;
        rp_inc = {1'b0, rp_eff} + 1'b1;
        cp_next = cp_eff;
        if (!ctrl.chroma || bir_eff[0])
            cp_next = (cp_inc >= {1'b0, factor}) ? '0 : cp_inc[nfd_pkg::FACTOR_W-1:0];

        bir_inc = {1'b0, bir_eff} + 1'b1;
        row_end = (bir_inc >= {1'b0, stride});

        kr_next = kr_eff;
        rp_next = rp_eff;
        if (row_end)
        begin
            bir_next = '0;
            cp_next  = '0;
            kc_next  = '0;
            if (row_kept)
                kr_next = kr_eff + 1'b1;
            rp_next = (rp_inc >= {1'b0, factor}) ? '0 : rp_inc[nfd_pkg::FACTOR_W-1:0];
        end
        else
        begin
            bir_next = bir_inc[nfd_pkg::STRIDE_W-1:0];
            kc_next  = stat.kept ? kc_inc : kc_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bir_reg <= '0;
            rp_reg  <= '0;
            cp_reg  <= '0;
            kr_reg  <= '0;
            kc_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            bir_reg <= bir_next;
            rp_reg  <= rp_next;
            cp_reg  <= cp_next;
            kr_reg  <= kr_next;
            kc_reg  <= kc_next;
        end
        else if (ctrl.clear)
        begin
            bir_reg <= '0;
            rp_reg  <= '0;
            cp_reg  <= '0;
            kr_reg  <= '0;
            kc_reg  <= '0;
        end
    end

endmodule

>>> rtl/nv12_frame_decimator.sv
// ----------------------------------------------------------------------------
// nv12_frame_decimator
// Nearest-neighbor integer decimation of an NV12 frame byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  s_* takes one frame byte per word in memory order: luma plane, then UV
//  plane, rows padded to their stride; tuser marks chroma and plane start.
//  m_* gives the 16-byte header (tuser[0]) and then the kept bytes; tlast
//  closes the words caused by one input word, tuser[1] flags frame end.
//  cfg_* writes factor, source size and strides; write only while idle.
//  Throughput: one byte per cycle for plane bytes while m_tready stays
//  high; a kept byte shows on m_* in the cycle after it is taken. A luma
//  plane-start word runs the shared divider twice, then a multiply step,
//  then 16 header words and its own byte if that byte is kept.
//  A stalled receiver holds the output word; s_tready stays low until that
//  word is taken, whatever the next input would need.
//  Reset clears counters and output size; registers return to defaults
//  (factor 1, 640x480, strides 640).
// ----------------------------------------------------------------------------
module nv12_frame_decimator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // pixel_byte
    input  logic [1:0]                      s_tuser,   // is_chroma, plane_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // out_byte
    output logic [1:0]                      m_tuser,   // is_header, frame_done
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [nfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nfd_pkg::CFG_W-1:0]       cfg_data
);

    logic [nfd_pkg::FACTOR_W-1:0]  factor_reg;
    logic [nfd_pkg::DIM_W-1:0]     src_w_reg, src_h_reg;
    logic [nfd_pkg::STRIDE_W-1:0]  luma_str_reg, chroma_str_reg;
    logic [nfd_pkg::FACTOR_W-1:0]  f_eff;

    nfd_pkg::state_t               state_reg, state_next;
    logic [nfd_pkg::DIM_W-1:0]     out_w_reg, out_w_next, out_h_reg, out_h_next;
    logic [nfd_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [nfd_pkg::HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic [7:0]                    pix_reg, pix_next;

    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    m_data_reg, m_data_next;
    logic                          m_hdr_reg, m_hdr_next;
    logic                          m_done_reg, m_done_next;
    logic                          m_last_reg, m_last_next;

    logic                          slot_free, accept, hdr_start;
    logic                          div_start, div_done;
    logic [nfd_pkg::DIM_W-1:0]     div_dividend, div_q;
    nfd_pkg::pix_ctrl_t            pctrl;
    nfd_pkg::pix_stat_t            pstat;
    logic [nfd_pkg::DIM_W:0]       h_sum;
    logic [nfd_pkg::LEN_W-1:0]     hdr_word [4];
    logic [nfd_pkg::LEN_W-1:0]     hdr_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg     <= nfd_pkg::RST_FACTOR;
            src_w_reg      <= nfd_pkg::RST_SRC_WIDTH;
            src_h_reg      <= nfd_pkg::RST_SRC_HEIGHT;
            luma_str_reg   <= nfd_pkg::RST_STRIDE;
            chroma_str_reg <= nfd_pkg::RST_STRIDE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nfd_pkg::REG_FACTOR:     factor_reg     <= cfg_data[nfd_pkg::FACTOR_W-1:0];
                nfd_pkg::REG_SRC_WIDTH:  src_w_reg      <= cfg_data[nfd_pkg::DIM_W-1:0];
                nfd_pkg::REG_SRC_HEIGHT: src_h_reg      <= cfg_data[nfd_pkg::DIM_W-1:0];
                nfd_pkg::REG_LUMA_STR:   luma_str_reg   <= cfg_data[nfd_pkg::STRIDE_W-1:0];
                nfd_pkg::REG_CHROMA_STR: chroma_str_reg <= cfg_data[nfd_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign f_eff = (factor_reg == '0) ? nfd_pkg::FACTOR_W'(1) : factor_reg;

    nfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (f_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    nfd_pix u_pix (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (pctrl),
        .factor        (f_eff),
        .luma_stride   (luma_str_reg),
        .chroma_stride (chroma_str_reg),
        .out_width     (out_w_reg),
        .out_height    (out_h_reg),
        .stat          (pstat)
    );

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == nfd_pkg::ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign hdr_start = s_tuser[1] && !s_tuser[0];
    assign h_sum     = {1'b0, out_h_reg} + {2'b0, out_h_reg[nfd_pkg::DIM_W-1:1]};

    assign hdr_word[0] = nfd_pkg::HDR_MAGIC;
    assign hdr_word[1] = nfd_pkg::LEN_W'(out_w_reg);
    assign hdr_word[2] = nfd_pkg::LEN_W'(out_h_reg);
    assign hdr_word[3] = len_reg;
    assign hdr_sel     = hdr_word[hdr_idx_reg[3:2]];

    always_comb
    begin
        state_next   = state_reg;
        out_w_next   = out_w_reg;
        out_h_next   = out_h_reg;
        len_next     = len_reg;
        hdr_idx_next = hdr_idx_reg;
        pix_next     = pix_reg;
        div_start    = 1'b0;
        div_dividend = src_w_reg;
        pctrl.step   = 1'b0;
        pctrl.clear  = 1'b0;
        pctrl.chroma = 1'b0;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        m_hdr_next   = m_hdr_reg;
        m_done_next  = m_done_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            nfd_pkg::ST_IDLE:
            begin
                pctrl.chroma = s_tuser[0];
                if (accept)
                begin
                    pctrl.clear = s_tuser[1];
                    if (hdr_start)
                    begin
                        pix_next   = s_tdata;
                        div_start  = 1'b1;
                        state_next = nfd_pkg::ST_DIV_W;
                    end
                    else
                    begin
                        pctrl.step = 1'b1;
                        if (pstat.kept)
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = s_tdata;
                            m_hdr_next   = 1'b0;
                            m_done_next  = pstat.done;
                            m_last_next  = 1'b1;
                        end
                    end
                end
            end
            nfd_pkg::ST_DIV_W:
            begin
                div_dividend = src_h_reg;
                if (div_done)
                begin
                    out_w_next = {div_q[nfd_pkg::DIM_W-1:1], 1'b0};
                    div_start  = 1'b1;
                    state_next = nfd_pkg::ST_DIV_H;
                end
            end
            nfd_pkg::ST_DIV_H:
            begin
                if (div_done)
                begin
                    out_h_next = {div_q[nfd_pkg::DIM_W-1:1], 1'b0};
                    state_next = nfd_pkg::ST_MUL;
                end
            end
            nfd_pkg::ST_MUL:
            begin
                len_next     = nfd_pkg::LEN_W'(out_w_reg * h_sum);
                hdr_idx_next = '0;
                state_next   = nfd_pkg::ST_HDR;
            end
            nfd_pkg::ST_HDR:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = hdr_sel[8*hdr_idx_reg[1:0] +: 8];
                    m_hdr_next   = 1'b1;
                    m_done_next  = (len_reg == '0) && (hdr_idx_reg == '1);
                    m_last_next  = (hdr_idx_reg == '1) && !pstat.kept;
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == '1)
                        state_next = nfd_pkg::ST_PIX;
                end
            end
            nfd_pkg::ST_PIX:
            begin
                if (!pstat.kept || slot_free)
                begin
                    pctrl.step = 1'b1;
                    state_next = nfd_pkg::ST_IDLE;
                    if (pstat.kept)
                    begin
                        m_valid_next = 1'b1;
                        m_data_next  = pix_reg;
                        m_hdr_next   = 1'b0;
                        m_done_next  = pstat.done;
                        m_last_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = nfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nfd_pkg::ST_IDLE;
            out_w_reg   <= '0;
            out_h_reg   <= '0;
            hdr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_w_reg   <= out_w_next;
            out_h_reg   <= out_h_next;
            hdr_idx_reg <= hdr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        pix_reg    <= pix_next;
        m_data_reg <= m_data_next;
        m_hdr_reg  <= m_hdr_next;
        m_done_reg <= m_done_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_done_reg, m_hdr_reg};
    assign m_tlast  = m_last_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == nfd_pkg::ST_DIV_W || state_reg == nfd_pkg::ST_DIV_H))
        else $error("divider finished outside a divide state");

    a_out_size_even: assert property (@(posedge clk) disable iff (!rst_n)
        !out_w_reg[0] && !out_h_reg[0])
        else $error("output size not even");

    a_frame_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept && hdr_start |=> state_reg == nfd_pkg::ST_DIV_W)
        else $error("frame start did not start the width divide");

    a_hdr_ends_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nfd_pkg::ST_HDR && state_next == nfd_pkg::ST_PIX |=> m_valid_reg && m_hdr_reg)
        else $error("last header word missing");

endmodule
